// ===== rtl/swrl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared widths, register indexes and reset values of the sliding-window
// rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // Stream payload widths
  localparam int unsigned NOW_W     = 32;  // request timestamp
  localparam int unsigned WAIT_W    = 32;  // ticks until the oldest stamp expires
  localparam int unsigned PEND_W    = 6;   // stamps held after a request
  localparam int unsigned OUT_DW    = 40;  // wait_ticks + pending_count, byte padded
  localparam int unsigned OUT_UW    = 1;   // granted flag

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WINDOW_W   = 32;
  localparam int unsigned MAXC_W     = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 8'd1;

  // Register reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 32'd30;
  localparam logic [MAXC_W-1:0]   MAX_COUNT_RESET = 6'd20;

endpackage
`default_nettype wire

// ===== rtl/sliding_window_rate_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding-window-log rate limiter over a ring of granted request stamps.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item per handshake; tdata is its timestamp in
//   ticks (non-decreasing, differences taken modulo 2^TIME_WIDTH).
//   m_axis returns one result item per request: tuser is the grant flag,
//   tdata holds wait_ticks and the number of stamps held after the request.
//   The cfg channel writes window_ticks (index 0) and max_count (index 1);
//   other indexes are ignored. cfg_ready_o is always high; write only while
//   no request is in flight.
// Scan:
//   After a request is accepted, the block pops its expired stamps
//   (0..DEPTH of them) in turn: one read of the oldest entry, age check,
//   advance. The ring is a synchronous memory with one write port and one
//   registered read port. The next request is taken in the cycle after
//   the decision; s_axis_tready is low while a request scans.
// Reset:
//   rst_ni clears the stamp count, the oldest pointer and the output valid,
//   and loads window_ticks = 30, max_count = 20. Ring contents are not
//   cleared; only entries written since reset are read.
// Backpressure:
//   The result sits in an output register. A new request is accepted while
//   it waits; that request scans but holds its decision until the result
//   register is taken, so a stalled receiver adds its stall to the item.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Request stream. tdata: [31:0] now_time
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [swrl_pkg::NOW_W-1:0]            s_axis_tdata,
  // Result stream. tdata: [31:0] wait_ticks, [37:32] pending_count, [39:38] 0
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [swrl_pkg::OUT_DW-1:0]           m_axis_tdata,
  // tuser: [0] granted
  output logic [swrl_pkg::OUT_UW-1:0]           m_axis_tuser,
  // Configuration write channel
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [swrl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [swrl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import swrl_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int unsigned CMP_W = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Stamp ring
  logic [TIME_WIDTH-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]      rd_addr;
  logic [TIME_WIDTH-1:0] rd_data_q;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      oldest_q, oldest_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [WINDOW_W-1:0]   window_q, window_d;
  logic [MAXC_W-1:0]     maxc_q, maxc_d;
  logic                  out_valid_q, out_valid_d;
  logic                  granted_q, granted_d;
  logic [WAIT_W-1:0]     wait_q, wait_d;
  logic [PEND_W-1:0]     pend_q, pend_d;

  logic [TIME_WIDTH-1:0] age;
  logic                  age_in_window;
  logic [WAIT_W-1:0]     wait_left;
  logic [IDX_W-1:0]      oldest_inc;
  logic [IDX_W:0]        wr_sum;
  logic [EXT_W-1:0]      limit;
  logic                  below_limit;
  logic                  out_free;

  // Age of the oldest stamp against the window
  assign age           = now_q - rd_data_q;
  assign age_in_window = CMP_W'(age) <= CMP_W'(window_q);
  assign wait_left     = WAIT_W'(CMP_W'(window_q) - CMP_W'(age));

  assign oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  // Next free slot: oldest + count, wrapped once (count < DEPTH here)
  assign wr_sum  = (IDX_W + 1)'(oldest_q) + (IDX_W + 1)'(count_q);
  assign wr_addr = (wr_sum >= (IDX_W + 1)'(DEPTH)) ?
                   IDX_W'(wr_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(wr_sum);

  // Saturate the limit at the ring depth
  assign limit = (EXT_W'(maxc_q) < EXT_W'(DEPTH)) ? EXT_W'(maxc_q) : EXT_W'(DEPTH);
  assign below_limit = EXT_W'(count_q) < limit;

  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = OUT_UW'(granted_q);
  assign m_axis_tdata  = {(OUT_DW - WAIT_W - PEND_W)'(0), pend_q, wait_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    now_d       = now_q;
    window_d    = window_q;
    maxc_d      = maxc_q;
    out_valid_d = out_valid_q;
    granted_d   = granted_q;
    wait_d      = wait_q;
    pend_d      = pend_q;
    rd_addr     = oldest_q;
    wr_en       = 1'b0;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_TICKS: window_d = cfg_data_i[WINDOW_W-1:0];
        REG_MAX_COUNT:    maxc_d   = cfg_data_i[MAXC_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        // Latch the request and fetch the oldest stamp
        if (s_axis_tvalid) begin
          now_d   = TIME_WIDTH'(s_axis_tdata);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count_q != '0 && !age_in_window) begin
          // Expired: advance past it and fetch the next one
          oldest_d = oldest_inc;
          count_d  = count_q - 1'b1;
          rd_addr  = oldest_inc;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (below_limit) begin
            wr_en     = 1'b1;
            count_d   = count_q + 1'b1;
            granted_d = 1'b1;
            wait_d    = '0;
          end else begin
            granted_d = 1'b0;
            wait_d    = (count_q != '0) ? wait_left : '0;
          end
          pend_d = PEND_W'(EXT_W'(count_d));
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      oldest_q    <= '0;
      window_q    <= WINDOW_RESET;
      maxc_q      <= MAX_COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      window_q    <= window_d;
      maxc_q      <= maxc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    granted_q <= granted_d;
    wait_q    <= wait_d;
    pend_q    <= pend_d;
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= now_q;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/swrl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swrl_checker
// Port-level checks of the sliding-window rate limiter, bound to the top.
// ----------------------------------------------------------------------------
module swrl_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [swrl_pkg::OUT_DW-1:0]        m_axis_tdata,
  input wire [swrl_pkg::OUT_UW-1:0]        m_axis_tuser
);
  import swrl_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A granted request reports no wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[WAIT_W-1:0] == '0)
    else $error("grant with nonzero wait");

  // Busy scanning after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while scanning");

  // A new result only follows a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a request");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== test/sliding_window_rate_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_tb
// Self-checking bench for the sliding-window rate limiter. A short directed
// table walks the window edges, the limit extremes, ignored register writes,
// wrapping and decreasing timestamps. Random segments follow, each under its
// own window and limit. Every result item is compared field by field with a
// behavioral bench model of the stamp ring, or with its row's typed verdict.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_tb;
  import swrl_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned SETTLE      = DEPTH + 8;  // worst scan plus margin
  localparam int unsigned HOLD_CYCLES = 300;        // long receiver stall
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEG_ITEMS   = 75;
  localparam int unsigned SEG_COUNT   = 6;

  // Indexes outside the register list; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic              granted;
    logic [WAIT_W-1:0] wait_ticks;
    logic [PEND_W-1:0] pending;
  } verdict_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;     // register index for ROW_CFG
    logic [31:0]          value;   // timestamp or register data
    logic                 typed;   // use the typed verdict below
    verdict_t             verdict;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset, block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [NOW_W-1:0]      s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]     m_axis_tdata;
  logic [OUT_UW-1:0]     m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  sliding_window_rate_limiter #(
    .DEPTH     (DEPTH),
    .TIME_WIDTH(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] now_time
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] wait_ticks, [37:32] pending_count
    .m_axis_tuser (m_axis_tuser),   // [0] granted
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  verdict_t    verdict_q[$];        // results still owed by the block
  int unsigned errors       = 0;
  int unsigned req_cnt      = 0;
  int unsigned grant_cnt    = 0;
  int unsigned deny_cnt     = 0;
  int unsigned reg_writes   = 0;
  int unsigned stall_cnt    = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_req_cnt = 0;    // bumped by the stimulus to ask for a stall

  // Model of the limiter: stamp ring, oldest pointer, count and registers
  logic [31:0]       stamp_ring[DEPTH];
  int unsigned       head_idx   = 0;
  int unsigned       held       = 0;
  logic [31:0]       win_ticks  = WINDOW_RESET;
  logic [MAXC_W-1:0] grant_cap  = MAX_COUNT_RESET;

  // Expire stamps older than the window from the oldest end, then grant and
  // record the stamp if under the limit, else report the time to the next
  // expiry. Ages wrap at 32 bits, so a step back in time reads as very old.
  function automatic verdict_t rate_decide(input logic [31:0] now);
    verdict_t    v;
    int unsigned lim;
    logic [31:0] age;
    v   = '0;
    lim = (grant_cap < DEPTH) ? int'(grant_cap) : DEPTH;
    while (held != 0) begin
      age = now - stamp_ring[head_idx];
      if (age <= win_ticks) break;
      head_idx = (head_idx + 1) % DEPTH;
      held--;
    end
    if (held < lim) begin
      stamp_ring[(head_idx + held) % DEPTH] = now;
      held++;
      v.granted = 1'b1;
    end else if (held != 0) begin
      age = now - stamp_ring[head_idx];
      v.wait_ticks = (age <= win_ticks) ? win_ticks - age : '0;
    end
    v.pending = PEND_W'(held);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each item taken, drive tready with random stalls and
  // the occasional long hold-off
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_side
    verdict_t    want;
    int unsigned hold_left;
    int unsigned hold_seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result item with nothing expected: tuser %0h tdata %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("granted", 32'(want.granted), 32'(m_axis_tuser[0]));
        check_field("wait_ticks", want.wait_ticks, m_axis_tdata[31:0]);
        check_field("pending_count", 32'(want.pending), 32'(m_axis_tdata[37:32]));
        if (want.granted) grant_cnt++;
        else deny_cnt++;
      end
    end
    // Start a long hold-off whenever the stimulus asks for one
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
      stall_cnt++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one request; tvalid stays high after acceptance so that a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_request(input logic [31:0] now, input logic use_typed,
                              input verdict_t typed);
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    v = rate_decide(now);
    verdict_q.push_back(use_typed ? typed : v);
    req_cnt++;
  endtask

  // Drop tvalid and hold until every owed result has been taken, then let
  // any scan still in flight finish.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WINDOW_TICKS: win_ticks = data;
      REG_MAX_COUNT:    grant_cap = data[MAXC_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  stim_row_t plan[$];

  initial begin : stimulus
    logic [31:0] seg_win[SEG_COUNT];
    logic [31:0] seg_cap[SEG_COUNT];
    logic [31:0] t;
    logic [31:0] span;
    int unsigned r;

    seg_win = '{32'd30, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd7};
    seg_cap = '{32'd20, 32'd63,  32'd2, 32'd32,        32'd32, 32'd5};

    // Directed table. Typed verdicts only where the answer is plain:
    // the first grant after reset, a denial at exactly the window edge,
    // and a zero limit with every stamp expired.
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd0, 1'b1, '{1'b1, 32'd0, 6'd1}});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd0,  1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd30, 1'b0, '0});  // age equals window
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd31, 1'b0, '0});  // two stamps expire
    plan.push_back(stim_row_t'{ROW_CFG, REG_MAX_COUNT, 32'd2, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd40, 1'b0, '0});  // denied, wait left
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd60, 1'b1, '{1'b0, 32'd0, 6'd2}});
    plan.push_back(stim_row_t'{ROW_CFG, REG_MAX_COUNT, 32'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd200, 1'b1, '{1'b0, 32'd0, 6'd0}});
    plan.push_back(stim_row_t'{ROW_CFG, REG_MAX_COUNT, 32'd63, 1'b0, '0});  // saturates
    plan.push_back(stim_row_t'{ROW_CFG, REG_UNUSED_LO, 32'd5, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_CFG, REG_UNUSED_HI, 32'hFFFF_FFFF, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd200, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd5,   1'b0, '0});  // time steps back
    plan.push_back(stim_row_t'{ROW_CFG, REG_WINDOW_TICKS, 32'd0, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd5, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd6, 1'b0, '0});    // zero window expiry
    plan.push_back(stim_row_t'{ROW_CFG, REG_WINDOW_TICKS, 32'hFFFF_FFFF, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'hFFFF_FFFF, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd0,  1'b0, '0});   // wraps
    plan.push_back(stim_row_t'{ROW_CFG, REG_MAX_COUNT, 32'd1, 1'b0, '0});  // below held
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd10, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_CFG, REG_WINDOW_TICKS, 32'd30, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_CFG, REG_MAX_COUNT, 32'd20, 1'b0, '0});
    plan.push_back(stim_row_t'{ROW_REQ, 8'd0, 32'd100, 1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 18;
    rx_idle_pct = 80;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_request(plan[i].value, plan[i].typed, plan[i].verdict);
      end
    end

    // Random segments, each under its own window and limit. Most requests
    // advance time a little so the ring fills; some jump far enough to
    // expire a full ring, a few step back or land anywhere.
    t = 32'd100;
    for (int s = 0; s < SEG_COUNT; s++) begin
      if (s < 2) begin
        tx_idle_pct = 18;
        rx_idle_pct = 80;
      end else if (s < 4) begin
        tx_idle_pct = 80;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain();
      write_reg(REG_WINDOW_TICKS, seg_win[s]);
      write_reg(REG_MAX_COUNT, seg_cap[s]);
      if (s == 1) t = 32'hFFFF_FF80;  // run across the timestamp wrap
      span = (seg_win[s] > 32'd1000) ? 32'd100 : seg_win[s] * 2 + 2;

      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ((s == 1 && n == 10) || (s == 4 && n == 30)) hold_req_cnt <= hold_req_cnt + 1;
        if (n == 40) drain();
        r = $urandom_range(99);
        if (r < 3) t = t - $urandom_range(1, 1000);
        else if (r < 6) t = $urandom();
        else if (r < 70) t = t + $urandom_range(0, 3);
        else if (r < 95) t = t + $urandom_range(0, span);
        else t = t + span * 3 + $urandom_range(0, 1000);
        send_request(t, 1'b0, '0);
      end
    end

    drain();
    $display("summary: %0d requests, %0d granted, %0d denied", req_cnt, grant_cnt, deny_cnt);
    $display("summary: %0d register writes, %0d long result stalls, %0d errors",
             reg_writes, stall_cnt, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swrl_pkg.sv
rtl/sliding_window_rate_limiter.sv
rtl/swrl_checker.sv
test/sliding_window_rate_limiter_tb.sv
